>>> rtl/core/jgdc_pkg.sv
`timescale 1ns / 1ps
package jgdc_pkg;

  // register stages inside each conversion path
  localparam int unsigned NumStages = 6;
  // accepting edge to the edge at which the result is taken
  localparam int unsigned Latency = NumStages + 2;

  // calendar constants
  localparam int unsigned JalOffset = 1595;
  localparam int unsigned J2gBias   = 355668;
  localparam int unsigned G2jBias   = 355666;
  localparam int unsigned Cyc400    = 146097;
  localparam int unsigned Cyc100    = 36524;
  localparam int unsigned Cyc4      = 1461;
  localparam int unsigned YearDays  = 365;
  localparam int unsigned Cyc33     = 12053;
  localparam int unsigned FirstHalf = 186;

  // truncated reciprocals, quotient estimate is exact or one low
  localparam int unsigned Recip33    = (1 << 13) / 33;
  localparam int unsigned Recip100   = (1 << 13) / 100;
  localparam int unsigned Recip400   = (1 << 13) / 400;
  localparam int unsigned RecipCyc33 = (1 << 21) / Cyc33;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } src_date_t;

  typedef struct packed {
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } res_date_t;

  // days in the gregorian months before month index mon_idx (0 based)
  function automatic logic [8:0] greg_cum(input logic [3:0] mon_idx, input logic leap);
    logic [8:0] base;
    unique case (mon_idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      default: base = 9'd334;
    endcase
    greg_cum = base + 9'(leap && (mon_idx >= 4'd2));
  endfunction

endpackage

>>> rtl/core/jgdc_j2g.sv
`timescale 1ns / 1ps
module jgdc_j2g (
  input  logic                 clk,
  input  jgdc_pkg::src_date_t  src,
  output jgdc_pkg::res_date_t  res
);

  // stage 1: shifted year, estimate of year / 33, month offset (+31)
  logic [12:0] s1_jy_nxt, s1_jy_r;
  logic [20:0] prod33;
  logic [7:0]  s1_qe_nxt, s1_qe_r;
  logic [8:0]  s1_moff_nxt, s1_moff_r;
  logic [4:0]  s1_day_nxt, s1_day_r;

  always_comb begin
    s1_jy_nxt = 13'(src.year) + 13'(jgdc_pkg::JalOffset);
    prod33    = 21'(s1_jy_nxt) * 21'(jgdc_pkg::Recip33);
    s1_qe_nxt = prod33[20:13];
    if (src.month < 4'd7) begin
      s1_moff_nxt = 9'(src.month) * 9'd31;
    end else begin
      s1_moff_nxt = 9'(src.month) * 9'd30 + 9'd7;
    end
    s1_day_nxt = src.day;
  end

  // stage 2: fix quotient, running day count
  logic [12:0] r33_raw, r33;
  logic [7:0]  q33;
  logic [3:0]  quarter;
  logic [21:0] days_sum;
  logic [20:0] s2_days_nxt, s2_days_r;

  always_comb begin
    r33_raw = s1_jy_r - 13'(s1_qe_r) * 13'd33;
    if (r33_raw >= 13'd33) begin
      q33 = s1_qe_r + 8'd1;
      r33 = r33_raw - 13'd33;
    end else begin
      q33 = s1_qe_r;
      r33 = r33_raw;
    end
    quarter  = 4'((r33[5:0] + 6'd3) >> 2);
    // month offset is carried with +31, folded into the bias
    days_sum = 22'(s1_jy_r) * 22'd365 + 22'({q33, 3'b000}) + 22'(quarter)
             + 22'(s1_day_r) + 22'(s1_moff_r) - 22'(jgdc_pkg::J2gBias + 31);
    s2_days_nxt = days_sum[20:0];
  end

  // stage 3: 400-year cycles
  logic [3:0]  s3_k400_nxt, s3_k400_r;
  logic [20:0] base400;
  logic [17:0] s3_rem_nxt, s3_rem_r;

  always_comb begin
    s3_k400_nxt = 4'd0;
    base400     = 21'd0;
    for (int j = 1; j <= 11; j++) begin
      if (s2_days_r >= 21'(j * jgdc_pkg::Cyc400)) begin
        s3_k400_nxt = 4'(j);
        base400     = 21'(j * jgdc_pkg::Cyc400);
      end
    end
    s3_rem_nxt = 18'(s2_days_r - base400);
  end

  // stage 4: centuries, the first year of a later century is short
  logic [1:0]  s4_kc_nxt, s4_kc_r;
  logic [17:0] base100, t100;
  logic [15:0] s4_rem_nxt, s4_rem_r;
  logic [3:0]  s4_k400_r;

  always_comb begin
    s4_kc_nxt = 2'd0;
    base100   = 18'd0;
    for (int j = 1; j <= 3; j++) begin
      if (s3_rem_r >= 18'(j * jgdc_pkg::Cyc100 + 1)) begin
        s4_kc_nxt = 2'(j);
        base100   = 18'(j * jgdc_pkg::Cyc100);
      end
    end
    t100 = s3_rem_r - base100;
    if (s4_kc_nxt == 2'd0) begin
      s4_rem_nxt = 16'(s3_rem_r);
    end else if (t100 >= 18'd366) begin
      s4_rem_nxt = 16'(t100);
    end else begin
      s4_rem_nxt = 16'(t100 - 18'd1);
    end
  end

  // stage 5: 4-year cycles
  logic [4:0]  s5_c_nxt, s5_c_r;
  logic [15:0] base4;
  logic [10:0] s5_r_nxt, s5_r_r;
  logic [3:0]  s5_k400_r;
  logic [1:0]  s5_kc_r;

  always_comb begin
    s5_c_nxt = 5'd0;
    base4    = 16'd0;
    for (int j = 1; j <= 24; j++) begin
      if (s4_rem_r >= 16'(j * jgdc_pkg::Cyc4)) begin
        s5_c_nxt = 5'(j);
        base4    = 16'(j * jgdc_pkg::Cyc4);
      end
    end
    s5_r_nxt = 11'(s4_rem_r - base4);
  end

  // stage 6: year within the 4-year cycle, day of year, leap flag
  logic [1:0]  k1;
  logic [10:0] base1;
  logic [12:0] s6_gy_nxt, s6_gy_r;
  logic [8:0]  s6_gd_nxt, s6_gd_r;
  logic        s6_leap_nxt, s6_leap_r;

  always_comb begin
    k1    = 2'd0;
    base1 = 11'd0;
    for (int j = 1; j <= 3; j++) begin
      if (s5_r_r >= 11'(j * jgdc_pkg::YearDays + 1)) begin
        k1    = 2'(j);
        base1 = 11'(j * jgdc_pkg::YearDays);
      end
    end
    if (k1 == 2'd0) begin
      s6_gd_nxt = 9'(s5_r_r + 11'd1);
    end else begin
      s6_gd_nxt = 9'(s5_r_r - base1);
    end
    s6_gy_nxt = 13'(s5_k400_r) * 13'd400 + 13'(s5_kc_r) * 13'd100
              + 13'({s5_c_r, 2'b00}) + 13'(k1);
    // leap only in the first year of a 4-year cycle, unless a century year that is not a 400-year boundary
    s6_leap_nxt = (k1 == 2'd0) && ((s5_c_r != 5'd0) || (s5_kc_r == 2'd0));
  end

  always_ff @(posedge clk) begin
    s1_jy_r   <= s1_jy_nxt;
    s1_qe_r   <= s1_qe_nxt;
    s1_moff_r <= s1_moff_nxt;
    s1_day_r  <= s1_day_nxt;
    s2_days_r <= s2_days_nxt;
    s3_k400_r <= s3_k400_nxt;
    s3_rem_r  <= s3_rem_nxt;
    s4_k400_r <= s3_k400_r;
    s4_kc_r   <= s4_kc_nxt;
    s4_rem_r  <= s4_rem_nxt;
    s5_k400_r <= s4_k400_r;
    s5_kc_r   <= s4_kc_r;
    s5_c_r    <= s5_c_nxt;
    s5_r_r    <= s5_r_nxt;
    s6_gy_r   <= s6_gy_nxt;
    s6_gd_r   <= s6_gd_nxt;
    s6_leap_r <= s6_leap_nxt;
  end

  // month walk against cumulative month lengths
  logic [3:0] gm_idx;

  always_comb begin
    gm_idx = 4'd0;
    for (int j = 1; j <= 11; j++) begin
      if (s6_gd_r > jgdc_pkg::greg_cum(4'(j), s6_leap_r)) begin
        gm_idx = 4'(j);
      end
    end
    res.year  = s6_gy_r;
    res.month = gm_idx + 4'd1;
    res.day   = 5'(s6_gd_r - jgdc_pkg::greg_cum(gm_idx, s6_leap_r));
  end

endmodule

>>> rtl/core/jgdc_g2j.sv
`timescale 1ns / 1ps
module jgdc_g2j (
  input  logic                 clk,
  input  jgdc_pkg::src_date_t  src,
  output jgdc_pkg::res_date_t  res
);

  // stage 1: clamp month, leap-count operands and quotient estimates
  logic [3:0]  mm;
  logic [12:0] gy2;
  logic [19:0] prod100;
  logic [17:0] prod400;
  logic [11:0] s1_year_nxt, s1_year_r;
  logic [4:0]  s1_day_nxt, s1_day_r;
  logic [8:0]  s1_cum_nxt, s1_cum_r;
  logic [10:0] s1_a4_nxt, s1_a4_r;
  logic [12:0] s1_u100_nxt, s1_u100_r, s1_u400_nxt, s1_u400_r;
  logic [6:0]  s1_e100_nxt, s1_e100_r;
  logic [4:0]  s1_e400_nxt, s1_e400_r;

  always_comb begin
    if (src.month == 4'd0) begin
      mm = 4'd1;
    end else if (src.month > 4'd12) begin
      mm = 4'd12;
    end else begin
      mm = src.month;
    end
    gy2         = 13'(src.year) + 13'(mm > 4'd2);
    s1_a4_nxt   = 11'((gy2 + 13'd3) >> 2);
    s1_u100_nxt = gy2 + 13'd99;
    s1_u400_nxt = gy2 + 13'd399;
    prod100     = 20'(s1_u100_nxt) * 20'(jgdc_pkg::Recip100);
    prod400     = 18'(s1_u400_nxt) * 18'(jgdc_pkg::Recip400);
    s1_e100_nxt = prod100[19:13];
    s1_e400_nxt = prod400[17:13];
    s1_cum_nxt  = jgdc_pkg::greg_cum(mm - 4'd1, 1'b0);
    s1_year_nxt = src.year;
    s1_day_nxt  = src.day;
  end

  // stage 2: fix quotients, running day count
  logic [12:0] r100, r400;
  logic [6:0]  q100;
  logic [4:0]  q400;
  logic [21:0] days_sum;
  logic [20:0] s2_days_nxt, s2_days_r;

  always_comb begin
    r100     = s1_u100_r - 13'(s1_e100_r) * 13'd100;
    r400     = s1_u400_r - 13'(s1_e400_r) * 13'd400;
    q100     = s1_e100_r + 7'(r100 >= 13'd100);
    q400     = s1_e400_r + 5'(r400 >= 13'd400);
    days_sum = 22'(jgdc_pkg::G2jBias) + 22'(s1_year_r) * 22'd365 + 22'(s1_a4_r)
             - 22'(q100) + 22'(q400) + 22'(s1_day_r) + 22'(s1_cum_r);
    s2_days_nxt = days_sum[20:0];
  end

  // stage 3: estimate of 33-year cycles
  logic [28:0] prod33;
  logic [7:0]  s3_e_nxt, s3_e_r;
  logic [20:0] s3_days_r;

  always_comb begin
    prod33   = 29'(s2_days_r) * 29'(jgdc_pkg::RecipCyc33);
    s3_e_nxt = prod33[28:21];
  end

  // stage 4: fix 33-year quotient
  logic [20:0] r33;
  logic [7:0]  s4_q_nxt, s4_q_r;
  logic [13:0] s4_rem_nxt, s4_rem_r;

  always_comb begin
    r33 = s3_days_r - 21'(s3_e_r) * 21'(jgdc_pkg::Cyc33);
    if (r33 >= 21'(jgdc_pkg::Cyc33)) begin
      s4_q_nxt   = s3_e_r + 8'd1;
      s4_rem_nxt = 14'(r33 - 21'(jgdc_pkg::Cyc33));
    end else begin
      s4_q_nxt   = s3_e_r;
      s4_rem_nxt = 14'(r33);
    end
  end

  // stage 5: 4-year cycles
  logic [3:0]  s5_c_nxt, s5_c_r;
  logic [13:0] base4;
  logic [10:0] s5_r_nxt, s5_r_r;
  logic [7:0]  s5_q_r;

  always_comb begin
    s5_c_nxt = 4'd0;
    base4    = 14'd0;
    for (int j = 1; j <= 8; j++) begin
      if (s4_rem_r >= 14'(j * jgdc_pkg::Cyc4)) begin
        s5_c_nxt = 4'(j);
        base4    = 14'(j * jgdc_pkg::Cyc4);
      end
    end
    s5_r_nxt = 11'(s4_rem_r - base4);
  end

  // stage 6: year within the 4-year cycle, day of year (0 based)
  logic [1:0]  k1;
  logic [10:0] base1;
  logic [12:0] s6_jy_nxt, s6_jy_r;
  logic [8:0]  s6_doy_nxt, s6_doy_r;

  always_comb begin
    k1    = 2'd0;
    base1 = 11'd0;
    for (int j = 1; j <= 3; j++) begin
      if (s5_r_r >= 11'(j * jgdc_pkg::YearDays + 1)) begin
        k1    = 2'(j);
        base1 = 11'(j * jgdc_pkg::YearDays + 1);
      end
    end
    s6_doy_nxt = 9'(s5_r_r - base1);
    // wraps to two's complement for years before the epoch
    s6_jy_nxt  = 13'(s5_q_r) * 13'd33 + 13'({s5_c_r, 2'b00}) + 13'(k1)
               - 13'(jgdc_pkg::JalOffset);
  end

  always_ff @(posedge clk) begin
    s1_year_r <= s1_year_nxt;
    s1_day_r  <= s1_day_nxt;
    s1_cum_r  <= s1_cum_nxt;
    s1_a4_r   <= s1_a4_nxt;
    s1_u100_r <= s1_u100_nxt;
    s1_u400_r <= s1_u400_nxt;
    s1_e100_r <= s1_e100_nxt;
    s1_e400_r <= s1_e400_nxt;
    s2_days_r <= s2_days_nxt;
    s3_days_r <= s2_days_r;
    s3_e_r    <= s3_e_nxt;
    s4_q_r    <= s4_q_nxt;
    s4_rem_r  <= s4_rem_nxt;
    s5_q_r    <= s4_q_r;
    s5_c_r    <= s5_c_nxt;
    s5_r_r    <= s5_r_nxt;
    s6_jy_r   <= s6_jy_nxt;
    s6_doy_r  <= s6_doy_nxt;
  end

  // month split: 31-day months first, then 30-day months
  logic [2:0] mk;
  logic [8:0] mb, t2;

  always_comb begin
    mk = 3'd0;
    mb = 9'd0;
    t2 = s6_doy_r - 9'(jgdc_pkg::FirstHalf);
    res.year = s6_jy_r;
    if (s6_doy_r < 9'(jgdc_pkg::FirstHalf)) begin
      for (int j = 1; j <= 5; j++) begin
        if (s6_doy_r >= 9'(j * 31)) begin
          mk = 3'(j);
          mb = 9'(j * 31);
        end
      end
      res.month = 4'(mk) + 4'd1;
      res.day   = 5'(s6_doy_r - mb) + 5'd1;
    end else begin
      for (int j = 1; j <= 5; j++) begin
        if (t2 >= 9'(j * 30)) begin
          mk = 3'(j);
          mb = 9'(j * 30);
        end
      end
      res.month = 4'(mk) + 4'd7;
      res.day   = 5'(t2 - mb) + 5'd1;
    end
  end

endmodule

>>> rtl/core/jalali_gregorian_date_converter_core.sv
`timescale 1ns / 1ps
// jalali / gregorian date converter
// input channel: drive in_op, in_year, in_month, in_day and raise start; the item
//   is taken at the rising edge where start is high and busy is low. busy is
//   always low, so a new item can be taken at every clock edge
// in_op = 0 converts a jalali date to gregorian, in_op = 1 the other way
// result channel: out_year, out_month, out_day hold for one cycle with out_valid
//   high; the receiver takes the item at the edge that ends that cycle and has
//   no way to hold it off
// pipeline: an accepted item passes the input register, six stage registers in each
//   conversion path and the result register, and out_valid rises with the result
//   register; the month split after the last stage register is combinational
// throughput: one item per cycle, results come back in the order taken
// both paths run side by side, in_op travels with the item and picks the result
// reset: synchronous, active low; drops every item in flight and clears
//   out_valid; no clearing pass, the block takes items right after reset
module jalali_gregorian_date_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  output logic        out_valid,
  output logic [12:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day
);

  localparam int unsigned Last = jgdc_pkg::NumStages;

  logic accept;

  // valid and direction travel next to the item through the stages
  logic [Last:0] vld_nxt, vld_r;
  logic [Last:0] op_nxt, op_r;
  logic          out_valid_nxt, out_valid_r;

  jgdc_pkg::src_date_t src_nxt, src_r;
  jgdc_pkg::res_date_t j2g_res, g2j_res;
  jgdc_pkg::res_date_t res_nxt, res_r;

  // no stage ever stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    vld_nxt       = {vld_r[Last-1:0], accept};
    op_nxt        = {op_r[Last-1:0], in_op};
    out_valid_nxt = vld_r[Last];
    // input register loads only on an accepted item
    if (accept) begin
      src_nxt = '{year: in_year, month: in_month, day: in_day};
    end else begin
      src_nxt = src_r;
    end
    // result register holds between items
    if (vld_r[Last]) begin
      res_nxt = op_r[Last] ? g2j_res : j2g_res;
    end else begin
      res_nxt = res_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    op_r  <= op_nxt;
    res_r <= res_nxt;
  end

  // jalali to gregorian path
  jgdc_j2g u_j2g (
    .clk (clk),
    .src (src_r),
    .res (j2g_res)
  );

  // gregorian to jalali path
  jgdc_g2j u_g2j (
    .clk (clk),
    .src (src_r),
    .res (g2j_res)
  );

  assign out_valid = out_valid_r;
  assign out_year  = res_r.year;
  assign out_month = res_r.month;
  assign out_day   = res_r.day;

  // every result month comes out of either month split in range
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_month != 4'd0) && (out_month <= 4'd12)))
    else $error("result month out of range");

  // each accepted item gives its result after the fixed latency
  a_fwd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(jgdc_pkg::Latency) out_valid)
    else $error("accepted item produced no result");

  // no result without an item taken the fixed latency earlier
  a_bwd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, jgdc_pkg::Latency))
    else $error("result without a matching item");

  // jalali day of month from the month split is never zero
  a_g2j_day: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[Last] && op_r[Last]) |=> (out_day != 5'd0))
    else $error("jalali result day is zero");

endmodule
